/* hw/rtl/b64d_pkg.sv */
// b64d_pkg: shared types and constants for the base64 stream decoder.
// No dependencies; imported by every module of the decoder.
package b64d_pkg;

   localparam int SEXTET_W   = 6;
   localparam int ACC_W      = 18;
   localparam int WORD_W     = 24;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL62 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL63 = 2'd1;

   localparam logic [7:0] SYMBOL62_RESET = 8'd43;
   localparam logic [7:0] SYMBOL63_RESET = 8'd47;

   localparam logic [7:0] CHAR_PAD     = 8'h3D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

   localparam logic [7:0] LOWER_OFFSET = 8'd71;  // 'a' - 26
   localparam logic [7:0] DIGIT_OFFSET = 8'd4;   // 52 - '0'

   localparam logic [SEXTET_W-1:0] SEXTET_62 = 6'd62;
   localparam logic [SEXTET_W-1:0] SEXTET_63 = 6'd63;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_LENGTH  = 2'd1,
      STATUS_PADDING = 2'd2
   } status_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [1:0]        count;
      logic              has_bytes;
      logic              last;
      status_type        status;
   } group_type;

endpackage

/* hw/rtl/base64_stream_decoder.sv */
// base64_stream_decoder: top level of the streaming base64 decoder.
// Depends on b64d_pkg, b64d_core, b64d_map and b64d_out.
//
//   channel  prefix  direction  payload
//   request  req_    in         text_char, message_end
//   response rsp_    out        data_byte, byte_valid, end_of_output, status
//   csr      csr_    in         index (0: symbol 62, 1: symbol 63), data
//
// One character is taken per cycle. A fourth character whose group yields bytes,
// or a message end, loads a result group (1 to 3 results) into the output slot,
// which then drains one result per cycle while rsp_ready is high; such a character
// waits until the slot is empty or its final result is taken. Results appear in the
// cycle after the transaction. Reset is synchronous and restores the default
// alphabet; csr writes always complete.
module base64_stream_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_text_char,
   input  logic                           req_message_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_data_byte,
   output logic                           rsp_byte_valid,
   output logic                           rsp_end_of_output,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [b64d_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_data
);
   import b64d_pkg::*;

   group_type grp;
   logic      grp_load, slot_ready;

   assign csr_ready = 1'b1;

   b64d_core u_core (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_text_char   (req_text_char),
      .req_message_end (req_message_end),
      .req_ready       (req_ready),
      .slot_ready      (slot_ready),
      .grp_load        (grp_load),
      .grp             (grp)
   );

   b64d_out u_out (
      .clock             (clock),
      .reset             (reset),
      .grp_load          (grp_load),
      .grp               (grp),
      .slot_ready        (slot_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_end_of_output (rsp_end_of_output),
      .rsp_status        (rsp_status)
   );

endmodule

/* hw/rtl/b64d_map.sv */
// b64d_map: maps one character to its sextet through the base64 alphabet.
// Depends on b64d_pkg.
module b64d_map (
   input  logic [7:0]                   text_char,
   input  logic [7:0]                   symbol62,
   input  logic [7:0]                   symbol63,
   output logic                         mapped,
   output logic                         is_pad,
   output logic [b64d_pkg::SEXTET_W-1:0] sextet
);
   import b64d_pkg::*;

   logic [7:0] diff;

   always_comb begin
      mapped = 1'b1;
      is_pad = 1'b0;
      diff   = '0;
      sextet = '0;
      if (text_char == CHAR_PAD) begin
         is_pad = 1'b1;
      end else if (text_char == symbol63) begin
         sextet = SEXTET_63;
      end else if (text_char == symbol62) begin
         sextet = SEXTET_62;
      end else if (text_char >= CHAR_UPPER_A && text_char <= CHAR_UPPER_Z) begin
         diff   = text_char - CHAR_UPPER_A;
         sextet = diff[SEXTET_W-1:0];
      end else if (text_char >= CHAR_LOWER_A && text_char <= CHAR_LOWER_Z) begin
         diff   = text_char - LOWER_OFFSET;
         sextet = diff[SEXTET_W-1:0];
      end else if (text_char >= CHAR_DIGIT_0 && text_char <= CHAR_DIGIT_9) begin
         diff   = text_char + DIGIT_OFFSET;
         sextet = diff[SEXTET_W-1:0];
      end else begin
         mapped = 1'b0;
      end
   end

endmodule

/* hw/rtl/b64d_core.sv */
// b64d_core: alphabet registers, group assembly state and result group build.
// Depends on b64d_pkg and b64d_map.
module b64d_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [b64d_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_data,
   input  logic                           req_valid,
   input  logic [7:0]                     req_text_char,
   input  logic                           req_message_end,
   output logic                           req_ready,
   input  logic                           slot_ready,
   output logic                           grp_load,
   output b64d_pkg::group_type            grp
);
   import b64d_pkg::*;

   logic [7:0]          symbol62_ff, symbol63_ff;
   logic [1:0]          pos_ff, pos_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [2:0]          pad_ff, pad_in;
   logic                stop_ff, stop_in;
   logic [1:0]          vcnt_ff, vcnt_in;
   logic                seen_ff, seen_in;
   logic                perr_ff, perr_in;

   logic                mapped, is_pad;
   logic [SEXTET_W-1:0] sextet;
   logic [2:0]          pad_sum;
   logic [1:0]          pad_low;
   logic                grp_full, produce, accept;

   b64d_map u_map (
      .text_char (req_text_char),
      .symbol62  (symbol62_ff),
      .symbol63  (symbol63_ff),
      .mapped    (mapped),
      .is_pad    (is_pad),
      .sextet    (sextet)
   );

   assign pad_sum   = pad_ff + {2'b00, is_pad};
   assign pad_low   = pad_sum[1:0];
   assign grp_full  = mapped && !stop_ff && (pos_ff == 2'd3);
   assign produce   = req_message_end || grp.has_bytes;
   assign req_ready = slot_ready || !produce;
   assign accept    = req_valid && req_ready;
   assign grp_load  = accept && produce;

   always_comb begin
      pos_in  = pos_ff;
      acc_in  = acc_ff;
      pad_in  = pad_ff;
      stop_in = stop_ff;
      vcnt_in = vcnt_ff;
      seen_in = seen_ff;
      perr_in = perr_ff;

      grp.has_bytes = grp_full && (pad_sum < 3'd3);
      grp.word      = grp.has_bytes ? {acc_ff, sextet} : '0;
      grp.count     = grp.has_bytes ? (2'd3 - pad_low) : 2'd1;
      grp.last      = req_message_end;

      if (mapped) begin
         vcnt_in = vcnt_ff + 2'd1;
         seen_in = 1'b1;
         if (!stop_ff) begin
            pad_in = pad_sum;
            if (pos_ff != 2'd3) begin
               acc_in = {acc_ff[ACC_W-SEXTET_W-1:0], sextet};
               pos_in = pos_ff + 2'd1;
            end else begin
               if (pad_sum >= 3'd3) begin
                  perr_in = 1'b1;
               end
               if (pad_sum != 3'd0) begin
                  stop_in = 1'b1;
               end
               pos_in = '0;
               acc_in = '0;
               pad_in = '0;
            end
         end
      end

      if (!seen_in || vcnt_in != 2'd0) begin
         grp.status = STATUS_LENGTH;
      end else if (perr_in) begin
         grp.status = STATUS_PADDING;
      end else begin
         grp.status = STATUS_OK;
      end

      if (req_message_end) begin
         pos_in  = '0;
         acc_in  = '0;
         pad_in  = '0;
         stop_in = 1'b0;
         vcnt_in = '0;
         seen_in = 1'b0;
         perr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol62_ff <= SYMBOL62_RESET;
         symbol63_ff <= SYMBOL63_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_SYMBOL62) begin
            symbol62_ff <= csr_data;
         end
         if (csr_index == CSR_SYMBOL63) begin
            symbol63_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         acc_ff  <= '0;
         pad_ff  <= '0;
         stop_ff <= 1'b0;
         vcnt_ff <= '0;
         seen_ff <= 1'b0;
         perr_ff <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         acc_ff  <= acc_in;
         pad_ff  <= pad_in;
         stop_ff <= stop_in;
         vcnt_ff <= vcnt_in;
         seen_ff <= seen_in;
         perr_ff <= perr_in;
      end
   end

endmodule

/* hw/rtl/b64d_out.sv */
// b64d_out: result group register and serializer, one result per cycle while rsp_ready is high.
// Depends on b64d_pkg.
module b64d_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                grp_load,
   input  b64d_pkg::group_type grp,
   output logic                slot_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_end_of_output,
   output logic [1:0]          rsp_status
);
   import b64d_pkg::*;

   group_type  slot_ff;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       at_last, rsp_take;

   assign at_last    = (idx_ff == slot_ff.count - 2'd1);
   assign rsp_take   = rsp_valid && rsp_ready;
   assign slot_ready = !busy_ff || (rsp_ready && at_last);

   assign rsp_valid         = busy_ff;
   assign rsp_byte_valid    = slot_ff.has_bytes;
   assign rsp_end_of_output = slot_ff.last && at_last;
   assign rsp_status        = rsp_end_of_output ? slot_ff.status : STATUS_OK;

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_data_byte = slot_ff.word[23:16];
         2'd1:    rsp_data_byte = slot_ff.word[15:8];
         default: rsp_data_byte = slot_ff.word[7:0];
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (rsp_take) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (grp_load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grp_load) begin
         slot_ff <= grp;
      end
   end

endmodule

/* hw/rtl/b64d_checker.sv */
// b64d_checker: port-level assertions for base64_stream_decoder, with its bind.
// Depends on b64d_pkg.
module b64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_end_of_output,
   input logic [1:0] rsp_status
);
   import b64d_pkg::*;

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_output |-> rsp_status == STATUS_OK)
      else $error("status set on a non-final result");

   a_empty_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_end_of_output)
      else $error("result without byte that does not end the message");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_LENGTH ||
                     rsp_status == STATUS_PADDING))
      else $error("undefined status code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte) &&
                                  $stable(rsp_end_of_output))
      else $error("stalled response changed");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_data_byte     (rsp_data_byte),
   .rsp_byte_valid    (rsp_byte_valid),
   .rsp_end_of_output (rsp_end_of_output),
   .rsp_status        (rsp_status)
);
